### hw/rtl/signal_run_statistics_core_assert.svh
// Assertion macros shared by the signal run statistics RTL.
// Expects signals named clk and rst in the including scope.
`ifndef SIGNAL_RUN_STATISTICS_CORE_ASSERT_SVH
`define SIGNAL_RUN_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/srs_pkg.sv
// Shared constants and types for the signal run statistics block.
// No dependencies.
package srs_pkg;

  // Fixed port field widths.
  localparam int TIME_FIELD_W  = 24;
  localparam int VALUE_FIELD_W = 16;
  localparam int AREA_FIELD_W  = 59;
  localparam int COUNT_FIELD_W = 17;

  // Default configuration.
  localparam int DEF_MAX_SAMPLES = 65536;
  localparam int DEF_TIME_BITS   = 24;
  localparam int DEF_VALUE_BITS  = 16;
  localparam int DEF_QUEUE_DEPTH = 2;

  // Summary queue status seen by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } queue_status_t;

endpackage

### hw/rtl/srs_front.sv
// Front end: accepts samples, keeps per-run running statistics and the
// doubled trapezoid area, and pushes one packed summary per closed run.
// Depends on srs_pkg.
module srs_front #(
  parameter int MAX_SAMPLES = srs_pkg::DEF_MAX_SAMPLES,
  parameter int TIME_BITS   = srs_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS  = srs_pkg::DEF_VALUE_BITS,
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W      = VALUE_BITS + CNT_W,
  localparam int PROD_W     = TIME_BITS + VALUE_BITS + 2,
  localparam int AREA_W     = PROD_W + CNT_W,
  localparam int PACK_W     = TIME_BITS + 2 * VALUE_BITS + SUM_W + AREA_W + CNT_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srs_pkg::TIME_FIELD_W-1:0]   sample_time,
  input  logic [srs_pkg::VALUE_FIELD_W-1:0]  sample_value,
  input  logic                               end_of_run,
  input  srs_pkg::queue_status_t             q_status,
  output logic                               push,
  output logic [PACK_W-1:0]                  push_data
);

  logic                          accept;
  logic [TIME_BITS-1:0]          t;
  logic signed [VALUE_BITS-1:0]  v;

  logic                          first_pending;
  logic [TIME_BITS-1:0]          prev_time;
  logic signed [VALUE_BITS-1:0]  prev_value;
  logic [TIME_BITS-1:0]          min_time, max_time;
  logic signed [VALUE_BITS-1:0]  min_value, max_value;
  logic signed [SUM_W-1:0]       value_sum;
  logic [CNT_W-1:0]              sample_count;
  logic signed [AREA_W-1:0]      double_area;

  logic [TIME_BITS-1:0]          min_time_next, max_time_next;
  logic signed [VALUE_BITS-1:0]  min_value_next, max_value_next;
  logic signed [SUM_W-1:0]       value_sum_next;
  logic [CNT_W-1:0]              sample_count_next;
  logic                          close_next;

  logic signed [TIME_BITS:0]     dt;
  logic signed [VALUE_BITS:0]    pair;
  logic signed [PROD_W-1:0]      prod_next;

  // product stage
  logic                          prod_valid;
  logic                          prod_last;
  logic signed [PROD_W-1:0]      prod;
  logic signed [AREA_W-1:0]      area_total;

  // snapshot of the closing run
  logic [TIME_BITS-1:0]          snap_span;
  logic signed [VALUE_BITS-1:0]  snap_min, snap_max;
  logic signed [SUM_W-1:0]       snap_sum;
  logic [CNT_W-1:0]              snap_count;

  logic                          close_pending;

  assign t = sample_time[TIME_BITS-1:0];
  assign v = sample_value[VALUE_BITS-1:0];

  assign close_pending = prod_valid && prod_last;
  // leave room for a summary already on its way to the queue
  assign in_ready = !q_status.full && !(close_pending && q_status.one_left);
  assign accept   = in_valid && in_ready;

  assign dt        = $signed({1'b0, t}) - $signed({1'b0, prev_time});
  assign pair      = (VALUE_BITS + 1)'(v) + (VALUE_BITS + 1)'(prev_value);
  assign prod_next = PROD_W'(pair) * PROD_W'(dt);

  always_comb begin
    if (first_pending) begin
      min_time_next     = t;
      max_time_next     = t;
      min_value_next    = v;
      max_value_next    = v;
      value_sum_next    = SUM_W'(v);
      sample_count_next = CNT_W'(1);
    end else begin
      min_time_next     = (t < min_time) ? t : min_time;
      max_time_next     = (t > max_time) ? t : max_time;
      min_value_next    = (v < min_value) ? v : min_value;
      max_value_next    = (v > max_value) ? v : max_value;
      value_sum_next    = value_sum + SUM_W'(v);
      sample_count_next = sample_count + CNT_W'(1);
    end
    close_next = end_of_run || (sample_count_next == CNT_W'(MAX_SAMPLES));
  end

  assign area_total = double_area + AREA_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      prod_valid    <= 1'b0;
      prod_last     <= 1'b0;
      double_area   <= '0;
    end else begin
      prod_valid <= accept;
      if (accept) begin
        first_pending <= close_next;
        prod_last     <= close_next;
      end
      if (prod_valid) begin
        double_area <= prod_last ? '0 : area_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_time    <= t;
      prev_value   <= v;
      min_time     <= min_time_next;
      max_time     <= max_time_next;
      min_value    <= min_value_next;
      max_value    <= max_value_next;
      value_sum    <= value_sum_next;
      sample_count <= sample_count_next;
      prod         <= first_pending ? '0 : prod_next;
      if (close_next) begin
        snap_span  <= max_time_next - min_time_next;
        snap_min   <= min_value_next;
        snap_max   <= max_value_next;
        snap_sum   <= value_sum_next;
        snap_count <= sample_count_next;
      end
    end
  end

  assign push      = close_pending;
  assign push_data = {snap_span, snap_min, snap_max, snap_sum, area_total, snap_count};

endmodule

### hw/rtl/srs_queue.sv
// Small register queue carrying run summaries from front to back end.
// Depends on srs_pkg for the status struct.
module srs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srs_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        pop_data,
  output srs_pkg::queue_status_t  status
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0] occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      occupancy <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        occupancy <= occupancy + OCC_W'(1);
      end else if (pop && !push) begin
        occupancy <= occupancy - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data        = entries[rd_ptr];
  assign status.empty    = (occupancy == '0);
  assign status.full     = (occupancy == OCC_W'(DEPTH));
  assign status.one_left = (occupancy == OCC_W'(DEPTH - 1));

endmodule

### hw/rtl/srs_back.sv
// Back end: pops a run summary, divides the value sum by the count one
// quotient bit per cycle, and holds the result until taken.
// Depends on srs_pkg.
module srs_back #(
  parameter int MAX_SAMPLES = srs_pkg::DEF_MAX_SAMPLES,
  parameter int TIME_BITS   = srs_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS  = srs_pkg::DEF_VALUE_BITS,
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W      = VALUE_BITS + CNT_W,
  localparam int PROD_W     = TIME_BITS + VALUE_BITS + 2,
  localparam int AREA_W     = PROD_W + CNT_W,
  localparam int PACK_W     = TIME_BITS + 2 * VALUE_BITS + SUM_W + AREA_W + CNT_W,
  localparam int STEP_W     = $clog2(SUM_W)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  srs_pkg::queue_status_t             q_status,
  input  logic [PACK_W-1:0]                  q_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srs_pkg::TIME_FIELD_W-1:0]   time_span,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  lowest_value,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  highest_value,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  mean_value,
  output logic [srs_pkg::AREA_FIELD_W-1:0]   area,
  output logic [srs_pkg::COUNT_FIELD_W-1:0]  samples_seen
);

  typedef enum logic [1:0] {IDLE, DIVIDE, DELIVER} state_t;

  state_t state;

  logic [TIME_BITS-1:0]          q_span;
  logic signed [VALUE_BITS-1:0]  q_min, q_max;
  logic signed [SUM_W-1:0]       q_sum;
  logic signed [AREA_W-1:0]      q_area;
  logic [CNT_W-1:0]              q_count;

  logic [TIME_BITS-1:0]          span_r;
  logic signed [VALUE_BITS-1:0]  min_r, max_r;
  logic signed [AREA_W-2:0]      area_r;
  logic [CNT_W-1:0]              count_r;
  logic                          neg_r;
  logic [SUM_W-1:0]              quo;
  logic [CNT_W-1:0]              rem;
  logic [STEP_W-1:0]             step;

  logic [CNT_W:0]                shifted;
  logic [CNT_W+1:0]              diff;
  logic [SUM_W-1:0]              quo_signed;
  logic signed [VALUE_BITS-1:0]  mean_w;

  assign {q_span, q_min, q_max, q_sum, q_area, q_count} = q_data;

  assign pop = (state == IDLE) && !q_status.empty;

  // restoring division step
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, count_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (pop) begin
            span_r  <= q_span;
            min_r   <= q_min;
            max_r   <= q_max;
            area_r  <= q_area[AREA_W-1:1];  // floor of half
            count_r <= q_count;
            neg_r   <= q_sum[SUM_W-1];
            quo     <= q_sum[SUM_W-1] ? -q_sum : q_sum;
            rem     <= '0;
            step    <= '0;
            state   <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (!diff[CNT_W+1]) begin
            rem <= diff[CNT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b1};
          end else begin
            rem <= shifted[CNT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= DELIVER;
          end
        end
        DELIVER: begin
          if (out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quo_signed = neg_r ? -quo : quo;
  assign mean_w     = quo_signed[VALUE_BITS-1:0];

  assign out_valid     = (state == DELIVER);
  assign time_span     = srs_pkg::TIME_FIELD_W'(span_r);
  assign lowest_value  = srs_pkg::VALUE_FIELD_W'(min_r);
  assign highest_value = srs_pkg::VALUE_FIELD_W'(max_r);
  assign mean_value    = srs_pkg::VALUE_FIELD_W'(mean_w);
  assign area          = srs_pkg::AREA_FIELD_W'(area_r);
  assign samples_seen  = srs_pkg::COUNT_FIELD_W'(count_r);

endmodule

### hw/rtl/signal_run_statistics_core.sv
// Signal run statistics core: top level tying front end, summary queue
// and divider back end together. Depends on srs_pkg, srs_front, srs_queue,
// srs_back and signal_run_statistics_core_assert.svh.
//
// Usage:
// - Input channel (in_valid/in_ready): one transaction per sample, carrying
//   sample_time, sample_value and end_of_run. Samples are taken one per cycle
//   while in_ready is high; a run closes on end_of_run or at MAX_SAMPLES samples.
// - Output channel (out_valid/out_ready): one transaction per closed run with
//   time span, min/max value, mean (truncated toward zero), trapezoidal area
//   (floor of doubled area halved) and sample count.
// - Result path: the closing sample's summary is registered in the front end,
//   pushed into the queue, popped by the idle back end, divided, then held.
// - Back end: the bit-serial mean divider takes no new run until the result
//   of the last one is taken. Samples stream at one per cycle while
//   in_ready is high; QUEUE_DEPTH closed runs can wait between front and back.
// - Receiver stall: the result holds on the outputs; the queue fills, then
//   in_ready drops until a slot frees up.
// - Reset (synchronous, active high): clears the run state, empties the
//   queue and drops any result in flight; the next sample starts a new run.
`include "signal_run_statistics_core_assert.svh"

module signal_run_statistics_core #(
  parameter int MAX_SAMPLES = srs_pkg::DEF_MAX_SAMPLES,
  parameter int TIME_BITS   = srs_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS  = srs_pkg::DEF_VALUE_BITS,
  parameter int QUEUE_DEPTH = srs_pkg::DEF_QUEUE_DEPTH,
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W      = VALUE_BITS + CNT_W,
  localparam int PROD_W     = TIME_BITS + VALUE_BITS + 2,
  localparam int AREA_W     = PROD_W + CNT_W,
  localparam int PACK_W     = TIME_BITS + 2 * VALUE_BITS + SUM_W + AREA_W + CNT_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srs_pkg::TIME_FIELD_W-1:0]   sample_time,
  input  logic [srs_pkg::VALUE_FIELD_W-1:0]  sample_value,
  input  logic                               end_of_run,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srs_pkg::TIME_FIELD_W-1:0]   time_span,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  lowest_value,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  highest_value,
  output logic [srs_pkg::VALUE_FIELD_W-1:0]  mean_value,
  output logic [srs_pkg::AREA_FIELD_W-1:0]   area,
  output logic [srs_pkg::COUNT_FIELD_W-1:0]  samples_seen
);

  srs_pkg::queue_status_t q_status;
  logic                   push;
  logic [PACK_W-1:0]      push_data;
  logic                   pop;
  logic [PACK_W-1:0]      pop_data;

  // Front: per-sample running statistics, one summary per closed run.
  srs_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .TIME_BITS   (TIME_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_time  (sample_time),
    .sample_value (sample_value),
    .end_of_run   (end_of_run),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  // Decoupling queue so sampling keeps going while the divider works.
  srs_queue #(
    .WIDTH (PACK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Back: mean division and the output register.
  srs_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .TIME_BITS   (TIME_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .time_span     (time_span),
    .lowest_value  (lowest_value),
    .highest_value (highest_value),
    .mean_value    (mean_value),
    .area          (area),
    .samples_seen  (samples_seen)
  );

  // A summary never arrives at a full queue: in_ready reserves its slot.
  `SRS_ASSERT_NOW(a_push_has_room, push, !q_status.full, "summary pushed into full queue")
  // The back end only pops what is there.
  `SRS_ASSERT_NOW(a_pop_not_empty, pop, !q_status.empty, "pop from empty queue")
  // A delivered result is followed by a fresh division, never a repeat.
  `SRS_ASSERT_NEXT(a_no_repeat, out_valid && out_ready, !out_valid,
                   "result presented twice")
  // Popping and presenting a result never overlap.
  `SRS_ASSERT_NOW(a_pop_idle_only, pop, !out_valid, "pop while result pending")

endmodule

### bench/tb_signal_run_statistics_core.sv
// Self-checking testbench for signal_run_statistics_core: streams runs of
// timestamped samples and checks every run summary against a local predictor.
// Depends on srs_pkg and the signal_run_statistics_core RTL.
module tb_signal_run_statistics_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 6;    // 12 ns period
  localparam int RESET_CYCLES   = 6;
  localparam int RUN_LIMIT      = srs_pkg::DEF_MAX_SAMPLES;
  localparam int RANDOM_SAMPLES = 500;
  localparam int GAP_MAX        = 14;
  localparam int IDLE_LIMIT     = 3000; // cycles with no transaction on either side
  localparam int DRAIN_CYCLES   = 80;
  localparam int REPORT_LIMIT   = 10;

  // One run summary as it leaves the block.
  typedef struct packed {
    logic [srs_pkg::TIME_FIELD_W-1:0]  time_span;
    logic [srs_pkg::VALUE_FIELD_W-1:0] lowest_value;
    logic [srs_pkg::VALUE_FIELD_W-1:0] highest_value;
    logic [srs_pkg::VALUE_FIELD_W-1:0] mean_value;
    logic [srs_pkg::AREA_FIELD_W-1:0]  area;
    logic [srs_pkg::COUNT_FIELD_W-1:0] samples_seen;
  } run_summary_t;

  // Tracks the open run and queues the summary of every closed one.
  class run_stats_scoreboard;
    bit                                       fresh;
    logic [srs_pkg::TIME_FIELD_W-1:0]         prev_t, t_lo, t_hi;
    logic signed [srs_pkg::VALUE_FIELD_W-1:0] prev_v, v_lo, v_hi;
    longint                                   sum;
    longint                                   dbl_area;
    int                                       count;
    run_summary_t                             summaries[$];
    int                                       mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      fresh    = 1'b1;
      prev_t   = '0;
      prev_v   = '0;
      t_lo     = '0;
      t_hi     = '0;
      v_lo     = '0;
      v_hi     = '0;
      sum      = 0;
      dbl_area = 0;
      count    = 0;
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Accepted input transaction.
    function void note_sample(logic [srs_pkg::TIME_FIELD_W-1:0] t,
                              logic [srs_pkg::VALUE_FIELD_W-1:0] raw_v,
                              logic last);
      logic signed [srs_pkg::VALUE_FIELD_W-1:0] v;
      run_summary_t                             s;
      v = raw_v;
      if (fresh) begin
        fresh    = 1'b0;
        t_lo     = t;
        t_hi     = t;
        v_lo     = v;
        v_hi     = v;
        sum      = 0;
        dbl_area = 0;
        count    = 0;
      end else begin
        // dt is signed: an earlier timestamp adds negative width
        dbl_area += (longint'(prev_v) + longint'(v)) * (longint'(t) - longint'(prev_t));
        if (t < t_lo) t_lo = t;
        if (t > t_hi) t_hi = t;
        if (v < v_lo) v_lo = v;
        if (v > v_hi) v_hi = v;
      end
      sum += v;
      count++;
      prev_t = t;
      prev_v = v;
      if (last || count >= RUN_LIMIT) begin
        s.time_span     = t_hi - t_lo;
        s.lowest_value  = v_lo;
        s.highest_value = v_hi;
        s.mean_value    = 16'(sum / count);      // truncates toward zero
        s.area          = 59'(dbl_area >>> 1);   // floor of half
        s.samples_seen  = 17'(count);
        summaries.push_back(s);
        restart();
      end
    endfunction

    // Accepted output transaction.
    function void check_result(run_summary_t got);
      run_summary_t want;
      if (summaries.size() == 0) begin
        fail($sformatf("result with no closed run pending: %h", got));
        return;
      end
      want = summaries.pop_front();
      if (got.time_span !== want.time_span)
        fail($sformatf("time_span: expected %0h, got %0h", want.time_span, got.time_span));
      if (got.lowest_value !== want.lowest_value)
        fail($sformatf("lowest_value: expected %0h, got %0h",
                       want.lowest_value, got.lowest_value));
      if (got.highest_value !== want.highest_value)
        fail($sformatf("highest_value: expected %0h, got %0h",
                       want.highest_value, got.highest_value));
      if (got.mean_value !== want.mean_value)
        fail($sformatf("mean_value: expected %0h, got %0h", want.mean_value, got.mean_value));
      if (got.area !== want.area)
        fail($sformatf("area: expected %0h, got %0h", want.area, got.area));
      if (got.samples_seen !== want.samples_seen)
        fail($sformatf("samples_seen: expected %0h, got %0h",
                       want.samples_seen, got.samples_seen));
    endfunction

    function int pending();
      return summaries.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [srs_pkg::TIME_FIELD_W-1:0] sample_time = '0;
  logic [srs_pkg::VALUE_FIELD_W-1:0] sample_value = '0;
  logic end_of_run = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [srs_pkg::TIME_FIELD_W-1:0] time_span;
  logic [srs_pkg::VALUE_FIELD_W-1:0] lowest_value;
  logic [srs_pkg::VALUE_FIELD_W-1:0] highest_value;
  logic [srs_pkg::VALUE_FIELD_W-1:0] mean_value;
  logic [srs_pkg::AREA_FIELD_W-1:0] area;
  logic [srs_pkg::COUNT_FIELD_W-1:0] samples_seen;

  run_stats_scoreboard sb = new();

  bit calm = 1'b0;                     // set: no idling on either side
  int idle_cycles = 0;
  logic [srs_pkg::TIME_FIELD_W-1:0] recent_time = '0;

  signal_run_statistics_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_time   (sample_time),
    .sample_value  (sample_value),
    .end_of_run    (end_of_run),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .time_span     (time_span),
    .lowest_value  (lowest_value),
    .highest_value (highest_value),
    .mean_value    (mean_value),
    .area          (area),
    .samples_seen  (samples_seen)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Timestamps: extremes, small forward steps (a real sampler) and full range.
  function automatic logic [srs_pkg::TIME_FIELD_W-1:0] draw_time();
    case ($urandom_range(0, 7))
      0: recent_time = '0;
      1: recent_time = '1;
      2, 3: recent_time = recent_time + srs_pkg::TIME_FIELD_W'($urandom_range(0, 40));
      default: recent_time = srs_pkg::TIME_FIELD_W'($urandom);
    endcase
    return recent_time;
  endfunction

  function automatic logic [srs_pkg::VALUE_FIELD_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return srs_pkg::VALUE_FIELD_W'($urandom);
    endcase
  endfunction

  // One input transaction. Valid drops only when a gap is drawn, so a
  // back-to-back sample keeps valid high with a single assignment per edge.
  task automatic send_sample(input logic [srs_pkg::TIME_FIELD_W-1:0] t,
                             input logic [srs_pkg::VALUE_FIELD_W-1:0] v,
                             input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_time  <= t;
    sample_value <= v;
    end_of_run   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: after each result, hold ready low for a drawn number of cycles.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor: both channels sampled with pre-edge values.
  always @(posedge clk) begin : monitor
    bit           moved;
    run_summary_t got;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_sample(sample_time, sample_value, end_of_run);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = {time_span, lowest_value, highest_value, mean_value, area, samples_seen};
        sb.check_result(got);
        moved = 1'b1;
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: a hung handshake on either side ends the run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int sent;
    int len;
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample runs at the field extremes.
    send_sample(24'd0, 16'h8000, 1'b1);
    send_sample(24'hFFFFFF, 16'h7FFF, 1'b1);
    // Largest positive and negative trapezoids.
    send_sample(24'd0, 16'h7FFF, 1'b0);
    send_sample(24'hFFFFFF, 16'h7FFF, 1'b1);
    send_sample(24'd0, 16'h8000, 1'b0);
    send_sample(24'hFFFFFF, 16'h8000, 1'b1);
    // Timestamps going backwards: negative width.
    send_sample(24'd1000, 16'h7FFF, 1'b0);
    send_sample(24'd500, 16'h8000, 1'b0);
    send_sample(24'hFFFFFF, 16'hFFFF, 1'b1);
    // Odd negative doubled area rounds down; mean -1/2 truncates to 0.
    send_sample(24'd0, 16'h0000, 1'b0);
    send_sample(24'd1, 16'hFFFF, 1'b1);
    // Mean -7/2 truncates toward zero to -3, area -21/2 floors to -11.
    send_sample(24'd10, 16'hFFFD, 1'b0);
    send_sample(24'd13, 16'hFFFC, 1'b1);
    // Repeated timestamps give zero width.
    send_sample(24'd7, 16'd5, 1'b0);
    send_sample(24'd7, 16'd5, 1'b0);
    send_sample(24'd7, 16'hAAAA, 1'b1);
    send_sample(24'h555555, 16'h5555, 1'b1);

    // Random runs, mostly short so summaries are frequent; some calm stretches
    // push several closed runs into the queue at once.
    while (sent < RANDOM_SAMPLES) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
        6, 7, 8: len = $urandom_range(5, 16);
        default: len = $urandom_range(17, 60);
      endcase
      for (int i = 0; i < len; i++)
        send_sample(draw_time(), draw_value(), i == len - 1);
      sent += len;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
